@@ rtl/core/mgig_pkg.sv @@
package mgig_pkg;

  // Array shape
  localparam int MAX_DIMS = 4;
  localparam int NUM_EXT  = 4;
  localparam int MAX_LIST = 256;

  // Field and storage widths
  localparam int EXT_W    = 12;
  localparam int LIST_AW  = $clog2(MAX_LIST);
  localparam int LEN_W    = $clog2(MAX_LIST + 1);
  localparam int ENTRY_W  = EXT_W + 1;
  localparam int STRIDE_W = EXT_W * (NUM_EXT - 1);
  localparam int IDX_W    = 48;
  localparam int LOC_W    = 32;
  localparam int DSEL_W   = 2;
  localparam int DCNT_W   = 3;
  localparam int CFG_AW   = 3;

  // Invalid flag of a stored subscript
  localparam int INVALID_BIT = EXT_W;

  // Load value of the hold-off counter that runs while the stride chain settles after a configuration write
  localparam int SETTLE   = NUM_EXT - 2;
  localparam int SETTLE_W = $clog2(SETTLE + 1);

  // Input sideband layout
  localparam int TU_CMD_LO  = 0;
  localparam int TU_DSEL_LO = 2;
  localparam int TU_NA      = 4;
  localparam int S_TUSER_W  = 5;

  // Output sideband layout
  localparam int TU_INDEX_NA  = 0;
  localparam int TU_EXHAUSTED = 1;
  localparam int M_TUSER_W    = 2;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_EXTENT_0    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_EXTENT_1    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_EXTENT_2    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_EXTENT_3    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_DIMS_IN_USE = 3'd4;
  localparam logic [CFG_AW-1:0] REG_FULL_MASK   = 3'd5;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_REWIND = 2'd2,
    CMD_NEXT   = 2'd3
  } cmd_t;

endpackage

@@ rtl/core/mgig_ram.sv @@
module mgig_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/multidim_gather_index_generator_top.sv @@
// Channel   Dir  Fields
// s_*       in   tdata: location; tuser: command, dim_select, location_na
// m_*       out  tdata: linear_index; tlast: last; tuser: index_na, exhausted
// cfg_*     in   extent_0..3, dims_in_use, full_mask (write only)
//
// An emit command's result is registered through stage B (subscript RAM read),
// stage C (stride multiply) and the output register (index sum).
// One command per cycle is taken while the output side keeps draining; the
// whole pipeline holds while a result waits at the output.
// Input is held off after reset and after every configuration write while the
// registered stride product chain settles.
// Reset is synchronous; the subscript RAMs are not cleared.
module multidim_gather_index_generator_top
  import mgig_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // command input
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [LOC_W-1:0]      s_tdata,   // [31:0] location
  input  logic [S_TUSER_W-1:0]  s_tuser,   // [1:0] command, [3:2] dim_select, [4] location_na
  // index output
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [IDX_W-1:0]      m_tdata,   // [47:0] linear_index
  output logic                  m_tlast,
  output logic [M_TUSER_W-1:0]  m_tuser,   // [0] index_na, [1] exhausted
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_AW-1:0]     cfg_index,
  input  logic [EXT_W-1:0]      cfg_wdata
);

  // Configuration registers
  logic [EXT_W-1:0]   extent [NUM_EXT];
  logic [DCNT_W-1:0]  dims_in_use;
  logic [NUM_EXT-1:0] full_mask;
  logic [SETTLE_W-1:0] settle;

  // Run state
  logic [LEN_W-1:0] list_length      [MAX_DIMS];
  logic [LEN_W-1:0] list_length_next [MAX_DIMS];
  logic [EXT_W-1:0] position         [MAX_DIMS];
  logic [EXT_W-1:0] position_next    [MAX_DIMS];
  logic             run_done;
  logic             run_done_next;

  // Strides: product of the extents below each dimension
  logic [STRIDE_W-1:0] stride [NUM_EXT];

  // Handshake
  logic adv;
  logic acc;
  cmd_t cmd;
  logic [DSEL_W-1:0] dsel;
  logic loc_invalid;

  // Emit stage A (combinational on current state)
  logic [DCNT_W-1:0]  dims_used;
  logic [MAX_DIMS-1:0] dim_on;
  logic [EXT_W-1:0]   count   [MAX_DIMS];
  logic [EXT_W-1:0]   pos_adv [MAX_DIMS];
  logic               empty_a;
  logic               exh_a;
  logic               carry_a;

  // Stage B: after the RAM read
  logic                b_valid;
  logic                b_exh;
  logic                b_last;
  logic [MAX_DIMS-1:0] b_on;
  logic [MAX_DIMS-1:0] b_full;
  logic [EXT_W-1:0]    b_pos  [MAX_DIMS];
  logic [ENTRY_W-1:0]  rd_entry [MAX_DIMS];
  logic [EXT_W:0]      sub_b  [MAX_DIMS];
  logic [EXT_W-1:0]    sub_m1 [MAX_DIMS];
  logic [MAX_DIMS-1:0] bad_dim;
  logic [IDX_W-1:0]    term_b [MAX_DIMS];

  // Stage C: after the multipliers
  logic             c_valid;
  logic             c_exh;
  logic             c_last;
  logic             c_bad;
  logic [IDX_W-1:0] c_term [MAX_DIMS];
  logic [IDX_W-1:0] idx_sum;

  assign cmd         = cmd_t'(s_tuser[TU_CMD_LO +: 2]);
  assign dsel        = s_tuser[TU_DSEL_LO +: DSEL_W];
  assign loc_invalid = s_tuser[TU_NA] || (s_tdata == '0) ||
                       (s_tdata > LOC_W'((1 << EXT_W) - 1));

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && (settle == '0);
  assign acc      = s_tvalid && s_tready;

  // Configuration writes; hold input off while strides settle
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_EXT; k++) begin
        extent[k] <= EXT_W'(1);
      end
      dims_in_use <= DCNT_W'(1);
      full_mask   <= '0;
      settle      <= SETTLE_W'(SETTLE);
    end else begin
      if (cfg_we) begin
        settle <= SETTLE_W'(SETTLE);
        unique case (cfg_index)
          REG_EXTENT_0:    extent[0]   <= cfg_wdata;
          REG_EXTENT_1:    extent[1]   <= cfg_wdata;
          REG_EXTENT_2:    extent[2]   <= cfg_wdata;
          REG_EXTENT_3:    extent[3]   <= cfg_wdata;
          REG_DIMS_IN_USE: dims_in_use <= cfg_wdata[DCNT_W-1:0];
          REG_FULL_MASK:   full_mask   <= cfg_wdata[NUM_EXT-1:0];
          default: ;
        endcase
      end else if (settle != '0) begin
        settle <= settle - SETTLE_W'(1);
      end
    end
  end

  // Stride chain, one multiply per register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_EXT; k++) begin
        stride[k] <= STRIDE_W'(1);
      end
    end else begin
      stride[0] <= STRIDE_W'(1);
      for (int k = 1; k < NUM_EXT; k++) begin
        stride[k] <= STRIDE_W'(stride[k-1] *
                     {{(STRIDE_W-EXT_W){1'b0}}, extent[k-1]});
      end
    end
  end

  // Emit stage A: emptiness check and odometer advance
  always_comb begin
    priority if (dims_in_use == '0) begin
      dims_used = DCNT_W'(1);
    end else if (dims_in_use > DCNT_W'(MAX_DIMS)) begin
      dims_used = DCNT_W'(MAX_DIMS);
    end else begin
      dims_used = dims_in_use;
    end
    empty_a = 1'b0;
    carry_a = 1'b1;
    for (int k = 0; k < MAX_DIMS; k++) begin
      dim_on[k]  = (DCNT_W'(k) < dims_used);
      count[k]   = full_mask[k] ? extent[k] : EXT_W'(list_length[k]);
      pos_adv[k] = position[k];
      if (dim_on[k] && (position[k] >= count[k])) begin
        empty_a = 1'b1;
      end
      if (dim_on[k] && carry_a) begin
        if (({1'b0, position[k]} + (EXT_W+1)'(1)) >= {1'b0, count[k]}) begin
          pos_adv[k] = '0;
        end else begin
          pos_adv[k] = position[k] + EXT_W'(1);
          carry_a    = 1'b0;
        end
      end
    end
    exh_a = run_done || empty_a;
  end

  // Next run state per command
  always_comb begin
    run_done_next = run_done;
    for (int k = 0; k < MAX_DIMS; k++) begin
      position_next[k]    = position[k];
      list_length_next[k] = list_length[k];
    end
    if (acc) begin
      unique case (cmd)
        CMD_CLEAR: begin
          run_done_next = 1'b0;
          for (int k = 0; k < MAX_DIMS; k++) begin
            position_next[k]    = '0;
            list_length_next[k] = '0;
          end
        end
        CMD_APPEND: begin
          for (int k = 0; k < MAX_DIMS; k++) begin
            if ((dsel == DSEL_W'(k)) && (list_length[k] < LEN_W'(MAX_LIST))) begin
              list_length_next[k] = list_length[k] + LEN_W'(1);
            end
          end
        end
        CMD_REWIND: begin
          run_done_next = 1'b0;
          for (int k = 0; k < MAX_DIMS; k++) begin
            position_next[k] = '0;
          end
        end
        CMD_NEXT: begin
          if (exh_a) begin
            run_done_next = 1'b1;
          end else begin
            run_done_next = carry_a;
            for (int k = 0; k < MAX_DIMS; k++) begin
              position_next[k] = pos_adv[k];
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_done <= 1'b0;
      for (int k = 0; k < MAX_DIMS; k++) begin
        position[k]    <= '0;
        list_length[k] <= '0;
      end
    end else begin
      run_done <= run_done_next;
      for (int k = 0; k < MAX_DIMS; k++) begin
        position[k]    <= position_next[k];
        list_length[k] <= list_length_next[k];
      end
    end
  end

  // One subscript RAM per dimension, read at the current position
  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_list
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_wdata;

    assign ram_we = acc && (cmd == CMD_APPEND) && (dsel == DSEL_W'(g)) &&
                    (list_length[g] < LEN_W'(MAX_LIST));
    assign ram_wdata = loc_invalid ? ENTRY_W'(1 << INVALID_BIT)
                                   : {1'b0, s_tdata[EXT_W-1:0]};

    mgig_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_LIST)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (list_length[g][LIST_AW-1:0]),
      .wdata (ram_wdata),
      .re    (acc && (cmd == CMD_NEXT)),
      .raddr (position[g][LIST_AW-1:0]),
      .rdata (rd_entry[g])
    );
  end

  // Stage B registers
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= acc && (cmd == CMD_NEXT);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_exh  <= exh_a;
      b_last <= carry_a;
      b_on   <= dim_on;
      b_full <= full_mask[MAX_DIMS-1:0];
      for (int k = 0; k < MAX_DIMS; k++) begin
        b_pos[k] <= position[k];
      end
    end
  end

  // Stage B: subscript check and scaled offset per dimension
  always_comb begin
    for (int k = 0; k < MAX_DIMS; k++) begin
      sub_b[k] = b_full[k] ? ({1'b0, b_pos[k]} + (EXT_W+1)'(1))
                           : {1'b0, rd_entry[k][EXT_W-1:0]};
      sub_m1[k] = EXT_W'(sub_b[k] - (EXT_W+1)'(1));
      bad_dim[k] = b_on[k] && ((!b_full[k] && rd_entry[k][INVALID_BIT]) ||
                   (sub_b[k] == '0) || (sub_b[k] > {1'b0, extent[k]}));
      term_b[k] = IDX_W'({{(IDX_W-EXT_W){1'b0}}, sub_m1[k]} *
                         {{(IDX_W-STRIDE_W){1'b0}}, stride[k]});
      if (!b_on[k]) begin
        term_b[k] = '0;
      end
    end
  end

  // Stage C registers
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_exh  <= b_exh;
      c_last <= b_last;
      c_bad  <= |bad_dim;
      for (int k = 0; k < MAX_DIMS; k++) begin
        c_term[k] <= term_b[k];
      end
    end
  end

  // Stage C: sum the offsets
  always_comb begin
    idx_sum = IDX_W'(1);
    for (int k = 0; k < MAX_DIMS; k++) begin
      idx_sum = idx_sum + c_term[k];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata                <= (c_exh || c_bad) ? '0 : idx_sum;
      m_tlast                <= !c_exh && c_last;
      m_tuser[TU_INDEX_NA]   <= !c_exh && c_bad;
      m_tuser[TU_EXHAUSTED]  <= c_exh;
    end
  end

`ifndef SYNTHESIS
  // An exhausted answer carries nothing else
  a_exh_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[TU_EXHAUSTED] |->
      (m_tdata == '0) && !m_tuser[TU_INDEX_NA] && !m_tlast)
    else $error("exhausted result carries index, NA or last");

  // Input held off while the strides settle after a write
  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_tready)
    else $error("command accepted right after a configuration write");

  // A finished run stays finished until a rewind or clear
  a_run_done_holds: assert property (@(posedge clk) disable iff (rst)
    run_done && !(acc && (cmd == CMD_CLEAR || cmd == CMD_REWIND)) |=> run_done)
    else $error("run reopened without rewind or clear");
`endif

endmodule

@@ tb/multidim_gather_index_generator_top_tb.sv @@
module multidim_gather_index_generator_top_tb
  import mgig_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EXT_MAX      = 2**EXT_W - 1;
  localparam int RANDOM_ITEMS = 1450;
  localparam int DRAIN_GAP    = 8;
  localparam int END_GAP      = 20;
  localparam int HOLD_OFF     = 400;
  localparam int STUCK_LIMIT  = 5000;

  // Register indexes the block decodes as nothing
  localparam logic [CFG_AW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_AW-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [ENTRY_W-1:0] ENTRY_INVALID = ENTRY_W'(1) << INVALID_BIT;

  typedef struct packed {
    cmd_t             cmd;
    logic [1:0]       dsel;
    logic [LOC_W-1:0] loc;
    logic             na;
  } gather_cmd_s;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             index_na;
    logic             last;
    logic             exhausted;
  } index_res_s;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [LOC_W-1:0]     s_tdata   = '0;
  logic [S_TUSER_W-1:0] s_tuser   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [IDX_W-1:0]     m_tdata;
  logic                 m_tlast;
  logic [M_TUSER_W-1:0] m_tuser;
  logic                 cfg_we    = 1'b0;
  logic [CFG_AW-1:0]    cfg_index = '0;
  logic [EXT_W-1:0]     cfg_wdata = '0;

  multidim_gather_index_generator_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [31:0] location
    .s_tuser   (s_tuser),   // [1:0] command, [3:2] dim_select, [4] location_na
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // [47:0] linear_index
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),   // [0] index_na, [1] exhausted
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Commands waiting to go out, and indexes waiting to come back
  gather_cmd_s cmd_q[$];
  index_res_s  index_q[$];
  gather_cmd_s offer;
  index_res_s  head;

  int errors        = 0;
  int queued_random = 0;
  int stuck_cycles  = 0;
  bit no_idle       = 1'b0;
  bit hold_req      = 1'b0;
  bit hold_done     = 1'b0;
  int hold_left     = 0;

  // Shadow of the block: registers, subscript lists and odometer
  logic [EXT_W-1:0]   ext_reg [NUM_EXT] = '{default: EXT_W'(1)};
  logic [DCNT_W-1:0]  dims_reg  = DCNT_W'(1);
  logic [MAX_DIMS-1:0] fmask_reg = '0;
  logic [ENTRY_W-1:0] subs_mem [MAX_DIMS][MAX_LIST];
  int                 list_len [MAX_DIMS] = '{default: 0};
  int                 pos      [MAX_DIMS] = '{default: 0};
  bit                 run_over = 1'b0;

  function automatic int dim_span(input int k);
    return fmask_reg[k] ? int'(ext_reg[k]) : list_len[k];
  endfunction

  // Apply one accepted command to the shadow; queue the index it yields
  function automatic void step_gather(input gather_cmd_s c);
    index_res_s       res;
    int               nd, k;
    int unsigned      s;
    logic [ENTRY_W-1:0] ent;
    logic [63:0]      idx, stride;
    bit               bad, empty, carry;
    res = '0;
    idx = 64'd1;
    stride = 64'd1;
    bad = 1'b0;
    empty = 1'b0;
    carry = 1'b1;
    case (c.cmd)
      CMD_CLEAR, CMD_REWIND: begin
        if (c.cmd == CMD_CLEAR) list_len = '{default: 0};
        pos = '{default: 0};
        run_over = 1'b0;
      end
      CMD_APPEND: begin
        if (list_len[c.dsel] < MAX_LIST) begin
          subs_mem[c.dsel][list_len[c.dsel]] =
            (c.na || c.loc == 0 || c.loc > EXT_MAX) ? ENTRY_INVALID
                                                    : {1'b0, c.loc[EXT_W-1:0]};
          list_len[c.dsel]++;
        end
      end
      default: begin
        nd = (dims_reg == 0) ? 1 : (dims_reg > MAX_DIMS) ? MAX_DIMS : int'(dims_reg);
        for (k = 0; k < nd; k++)
          if (pos[k] >= dim_span(k)) empty = 1'b1;
        if (run_over || empty) begin
          run_over = 1'b1;
          res.exhausted = 1'b1;
        end else begin
          // Sum the weighted subscripts, column major
          for (k = 0; k < nd; k++) begin
            if (fmask_reg[k]) begin
              s = pos[k] + 1;
            end else begin
              ent = subs_mem[k][pos[k]];
              s = ent[INVALID_BIT] ? 0 : ent[EXT_W-1:0];
            end
            if (s < 1 || s > ext_reg[k]) bad = 1'b1;
            else idx += 64'(s - 1) * stride;
            stride *= 64'(ext_reg[k]);
          end
          // Advance the odometer, dimension 0 fastest
          for (k = 0; k < nd && carry; k++) begin
            pos[k]++;
            if (pos[k] >= dim_span(k)) pos[k] = 0;
            else carry = 1'b0;
          end
          if (carry) run_over = 1'b1;
          res.index    = bad ? '0 : idx[IDX_W-1:0];
          res.index_na = bad;
          res.last     = carry;
        end
        index_q.insert(index_q.size(), res);
      end
    endcase
  endfunction

  // Sender: offer queued commands, idling at random
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) step_gather(offer);
      if (!s_tvalid || s_tready) begin
        if (cmd_q.size() > 0 && (no_idle || $urandom_range(99) >= 14)) begin
          offer = cmd_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= offer.loc;
          s_tuser  <= {offer.na, offer.dsel, offer.cmd};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic flag_field(input string name, input logic [IDX_W-1:0] want,
                            input logic [IDX_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  // Receiver: check each transaction against the oldest expected index
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (index_q.size() == 0) begin
          errors++;
          $display("%0t ns: expected no index, got %h na %b last %b exhausted %b", $time,
                   m_tdata, m_tuser[TU_INDEX_NA], m_tlast, m_tuser[TU_EXHAUSTED]);
        end else begin
          head = index_q.pop_front();
          flag_field("linear_index", head.index, m_tdata);
          flag_field("index_na", head.index_na, m_tuser[TU_INDEX_NA]);
          flag_field("last", head.last, m_tlast);
          flag_field("exhausted", head.exhausted, m_tuser[TU_EXHAUSTED]);
        end
      end
      // One long hold-off once a result is waiting, so the block backs up
      if (hold_req && !hold_done && m_tvalid) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= no_idle || $urandom_range(99) >= 14;
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic void push_cmd(input cmd_t cmd, input logic [1:0] dsel,
                                   input logic [LOC_W-1:0] loc, input logic na);
    gather_cmd_s c;
    c.cmd  = cmd;
    c.dsel = dsel;
    c.loc  = loc;
    c.na   = na;
    cmd_q.insert(cmd_q.size(), c);
  endfunction

  function automatic void push_next();
    push_cmd(CMD_NEXT, 2'($urandom()), $urandom(), 1'($urandom()));
  endfunction

  // Mostly in-range subscripts, the rest out of range or malformed
  function automatic logic [LOC_W-1:0] pick_location(input logic [EXT_W-1:0] ext);
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, (ext == 0) ? 1 : ext);
    if (r < 76) return ext + $urandom_range(1, 3);
    if (r < 82) return '0;
    if (r < 87) return {1'b1, 31'($urandom())};
    if (r < 92) return $urandom_range(EXT_MAX + 1, 32'h7FFF_FFFF);
    if (r < 96) return EXT_MAX;
    return $urandom();
  endfunction

  // Hold until nothing is queued, offered or outstanding, then let the pipe empty
  task automatic wait_drained();
    do @(negedge clk); while (cmd_q.size() != 0 || s_tvalid || index_q.size() != 0);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [EXT_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_EXTENT_0, REG_EXTENT_1, REG_EXTENT_2, REG_EXTENT_3: ext_reg[idx[1:0]] = val;
      REG_DIMS_IN_USE: dims_reg = val[DCNT_W-1:0];
      REG_FULL_MASK:   fmask_reg = val[MAX_DIMS-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_shape(input logic [EXT_W-1:0] e0, e1, e2, e3, dims_word,
                             mask_word);
    write_reg(REG_EXTENT_0, e0);
    write_reg(REG_EXTENT_1, e1);
    write_reg(REG_EXTENT_2, e2);
    write_reg(REG_EXTENT_3, e3);
    write_reg(REG_DIMS_IN_USE, dims_word);
    write_reg(REG_FULL_MASK, mask_word);
    if ($urandom_range(99) < 15)
      write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, EXT_W'($urandom()));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Random shape, random lists, then a walk through the combinations
  task automatic random_phase();
    logic [EXT_W-1:0]    ext [NUM_EXT];
    logic [DCNT_W-1:0]   dims;
    logic [MAX_DIMS-1:0] fm;
    int                  len [MAX_DIMS];
    int                  left [MAX_DIMS];
    int                  k, r, total, nd, n_next, i;
    longint unsigned     prod;
    bit                  do_clear;
    for (k = 0; k < NUM_EXT; k++) begin
      r = $urandom_range(99);
      ext[k] = (r < 5) ? '0 : (r < 10) ? EXT_W'(EXT_MAX) :
               (r < 16) ? EXT_W'($urandom_range(1, EXT_MAX)) : EXT_W'($urandom_range(1, 6));
    end
    dims = ($urandom_range(99) < 12) ? DCNT_W'($urandom_range(5, 8))
                                     : DCNT_W'($urandom_range(1, 4));
    fm = MAX_DIMS'($urandom_range(15));
    wait_drained();
    apply_shape(ext[0], ext[1], ext[2], ext[3],
                {(EXT_W - DCNT_W)'($urandom()), dims},
                {(EXT_W - MAX_DIMS)'($urandom()), fm});

    do_clear = $urandom_range(99) < 80;
    if (do_clear) push_cmd(CMD_CLEAR, 2'($urandom()), $urandom(), 1'($urandom()));
    total = 0;
    for (k = 0; k < MAX_DIMS; k++) begin
      len[k]  = ($urandom_range(99) < 8) ? 0 : $urandom_range(1, 4);
      left[k] = len[k];
      total  += len[k];
    end
    // Interleave appends across dimensions
    while (total > 0) begin
      k = $urandom_range(MAX_DIMS - 1);
      if (left[k] > 0) begin
        push_cmd(CMD_APPEND, 2'(k), pick_location(ext[k]), $urandom_range(99) < 6);
        left[k]--;
        total--;
      end
    end

    nd = (dims == 0) ? 1 : (dims > MAX_DIMS) ? MAX_DIMS : int'(dims);
    prod = 1;
    for (k = 0; k < nd; k++) prod *= fm[k] ? longint'(ext[k]) : longint'(len[k]);
    if (!do_clear) prod = 20;
    n_next = (prod <= 40) ? int'(prod) + $urandom_range(0, 2) : $urandom_range(8, 40);
    for (i = 0; i < n_next; i++) begin
      if ($urandom_range(99) < 7)
        push_cmd(cmd_t'($urandom_range(3)), 2'($urandom()), $urandom(), 1'($urandom()));
      push_next();
    end
    queued_random += cmd_q.size();
  endtask

  // Fill one list past its capacity and walk every combination, under back-pressure
  task automatic list_cap_phase();
    int i;
    wait_drained();
    apply_shape(EXT_W'(1), EXT_W'(7), EXT_W'(1), EXT_W'(1), EXT_W'(2), EXT_W'(1));
    push_cmd(CMD_CLEAR, 2'($urandom()), $urandom(), 1'($urandom()));
    for (i = 0; i < MAX_LIST + 2; i++)
      push_cmd(CMD_APPEND, 2'd1, pick_location(EXT_W'(7)), $urandom_range(99) < 4);
    for (i = 0; i < MAX_LIST / 2; i++) push_next();
    queued_random += cmd_q.size();
    hold_req = 1'b1;
    // Sender pauses until every outstanding index has come back
    wait_drained();
    for (i = 0; i < MAX_LIST / 2 + 4; i++) push_next();
    queued_random += cmd_q.size();
  endtask

  initial begin
    int ph;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Emit straight after reset: every list empty
    push_next();

    // Directed: subscript extremes, invalid entries, end of run, rewind
    wait_drained();
    apply_shape(EXT_W'(EXT_MAX), EXT_W'(3), EXT_W'(2), EXT_W'(EXT_MAX), EXT_W'(3),
                EXT_W'(4'b0100));
    push_cmd(CMD_CLEAR, 2'd0, '0, 1'b0);
    push_cmd(CMD_APPEND, 2'd0, LOC_W'(EXT_MAX), 1'b0);
    push_cmd(CMD_APPEND, 2'd0, '0, 1'b0);
    push_cmd(CMD_APPEND, 2'd1, LOC_W'(3), 1'b0);
    push_cmd(CMD_APPEND, 2'd1, LOC_W'(2), 1'b1);
    push_cmd(CMD_APPEND, 2'd1, LOC_W'(4), 1'b0);
    push_cmd(CMD_APPEND, 2'd3, 32'hFFFF_FFFF, 1'b0);
    push_cmd(CMD_APPEND, 2'd3, 32'h8000_0000, 1'b0);
    push_cmd(CMD_APPEND, 2'd3, 32'h7FFF_FFFF, 1'b1);
    push_cmd(CMD_APPEND, 2'd2, LOC_W'(EXT_MAX + 1), 1'b0);
    repeat (13) push_next();
    push_cmd(CMD_REWIND, 2'd3, 32'hFFFF_FFFF, 1'b1);
    push_next();

    // Stale position after the extent shrinks; dimension count of zero
    wait_drained();
    apply_shape(EXT_W'(1), EXT_W'(3), EXT_W'(2), EXT_W'(EXT_MAX), EXT_W'(0),
                EXT_W'(4'b0101));
    push_next();

    // Dimension count above the maximum saturates
    wait_drained();
    apply_shape(EXT_W'(1), EXT_W'(3), EXT_W'(2), EXT_W'(EXT_MAX), EXT_W'(7),
                EXT_W'(4'b0101));
    push_cmd(CMD_REWIND, 2'd0, '0, 1'b0);
    push_next();

    // Random phases, one of them filling a list to capacity
    ph = 0;
    while (queued_random < RANDOM_ITEMS) begin
      no_idle = (ph >= 10 && ph < 20);
      if (ph == 5) list_cap_phase();
      else random_phase();
      ph++;
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (END_GAP) @(negedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
